/* hw/rtl/assert_macros.svh */
// ---------------------------------------------------------------------------
// assert_macros
// Concurrent assertion helpers, empty in synthesis builds
// ---------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");
`else
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif

`endif

/* hw/rtl/dbcl_pkg.sv */
// ---------------------------------------------------------------------------
// dbcl_pkg
// Shared constants and types of the debounced button command latch
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package dbcl_pkg;

  localparam int CHANNEL_COUNT = 4;
  localparam int COUNT_WIDTH   = 16;
  localparam int CFG_WIDTH     = 16;
  localparam int FUNC_WIDTH    = 2;
  localparam int BTN_WIDTH     = 4;
  localparam int CMD_WIDTH     = 3;
  localparam int LED_WIDTH     = 4;
  localparam int CFG_IDX_WIDTH = 1;
  localparam int CMP_WIDTH     = (COUNT_WIDTH > CFG_WIDTH) ? COUNT_WIDTH : CFG_WIDTH;

  typedef logic [COUNT_WIDTH-1:0]   count_t;
  typedef logic [CFG_WIDTH-1:0]     cfg_t;
  typedef logic [CMP_WIDTH-1:0]     cmp_t;
  typedef logic [CMD_WIDTH-1:0]     cmd_t;
  typedef logic [CHANNEL_COUNT-1:0] chan_vec_t;

  typedef enum logic [FUNC_WIDTH-1:0] {
    FUNC_TICK  = 2'd0,
    FUNC_FETCH = 2'd1,
    FUNC_SHOW  = 2'd2,
    FUNC_OFF   = 2'd3
  } func_t;

  localparam logic [CFG_IDX_WIDTH-1:0] CFG_DEBOUNCE = 1'b0;
  localparam logic [CFG_IDX_WIDTH-1:0] CFG_FEEDBACK = 1'b1;

  localparam cfg_t DEBOUNCE_RESET = 16'd50;
  localparam cfg_t FEEDBACK_RESET = 16'd300;

  typedef struct packed {
    logic [LED_WIDTH-1:0] leds;
    logic                 command_valid;
    cmd_t                 command_taken;
    logic                 pending_flag;
  } result_t;

endpackage

/* hw/rtl/dbcl_lane.sv */
// ---------------------------------------------------------------------------
// dbcl_lane
// One button channel: raw level, stable level and saturating hold counter
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbcl_lane (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          tick_en,
  input  logic          raw,
  input  dbcl_pkg::cfg_t debounce_ms,
  output logic          press
);
  import dbcl_pkg::*;

  logic   last_raw_r, last_raw_nxt;
  logic   stable_r, stable_nxt;
  count_t since_r, since_nxt;
  logic   flip;

  always_comb begin
    last_raw_nxt = last_raw_r;
    since_nxt    = since_r;
    stable_nxt   = stable_r;
    flip         = 1'b0;
    if (tick_en) begin
      if (raw != last_raw_r) begin
        last_raw_nxt = raw;
        since_nxt    = '0;
      end else if (since_r != '1) begin
        since_nxt = since_r + count_t'(1);
      end
      flip = (cmp_t'(since_nxt) >= cmp_t'(debounce_ms)) && (raw != stable_r);
      if (flip) begin
        stable_nxt = raw;
      end
    end
  end

  assign press = flip & raw;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= 1'b0;
      stable_r   <= 1'b0;
      since_r    <= '0;
    end else begin
      last_raw_r <= last_raw_nxt;
      stable_r   <= stable_nxt;
      since_r    <= since_nxt;
    end
  end

endmodule

/* hw/rtl/dbcl_merge.sv */
// ---------------------------------------------------------------------------
// dbcl_merge
// Priority pick over lane presses, pending command slot and feedback timer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module dbcl_merge (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 fire,
  input  logic [dbcl_pkg::FUNC_WIDTH-1:0]      func,
  input  dbcl_pkg::cmd_t                       command_shown,
  input  dbcl_pkg::chan_vec_t                  press,
  input  dbcl_pkg::cfg_t                       feedback_ms,
  output dbcl_pkg::result_t                    res
);
  import dbcl_pkg::*;

  cmd_t      pending_r, pending_nxt;
  chan_vec_t leds_r, leds_nxt;
  cfg_t      left_r, left_nxt;
  logic      any_press;
  cmd_t      pick;
  logic      valid;
  cmd_t      taken;

  // lowest pressed channel wins
  always_comb begin
    any_press = 1'b0;
    pick      = '0;
    for (int i = CHANNEL_COUNT - 1; i >= 0; i--) begin
      if (press[i]) begin
        any_press = 1'b1;
        pick      = cmd_t'(i + 1);
      end
    end
  end

  always_comb begin
    pending_nxt = pending_r;
    leds_nxt    = leds_r;
    left_nxt    = left_r;
    valid       = 1'b0;
    taken       = '0;
    if (fire) begin
      case (func_t'(func))
        FUNC_TICK: begin
          if (left_r != '0) begin
            left_nxt = left_r - cfg_t'(1);
          end
          if (left_nxt == '0) begin
            leds_nxt = '0;
          end
          if (any_press && pending_r == '0) begin
            pending_nxt = pick;
            leds_nxt    = chan_vec_t'(1) << (pick - cmd_t'(1));
            left_nxt    = feedback_ms;
          end
        end
        FUNC_FETCH: begin
          if (pending_r != '0) begin
            valid       = 1'b1;
            taken       = pending_r;
            pending_nxt = '0;
          end
        end
        FUNC_SHOW: begin
          if (command_shown inside {[1:CHANNEL_COUNT]}) begin
            leds_nxt = chan_vec_t'(1) << (command_shown - cmd_t'(1));
            left_nxt = feedback_ms;
          end else begin
            leds_nxt = '0;
          end
        end
        FUNC_OFF: begin
          leds_nxt = '0;
        end
        default: begin
          leds_nxt = leds_r;
        end
      endcase
    end
  end

  always_comb begin
    res.leds          = LED_WIDTH'(leds_nxt);
    res.command_valid = valid;
    res.command_taken = taken;
    res.pending_flag  = (pending_nxt != '0);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      leds_r    <= '0;
      left_r    <= '0;
    end else begin
      pending_r <= pending_nxt;
      leds_r    <= leds_nxt;
      left_r    <= left_nxt;
    end
  end

endmodule

/* hw/rtl/debounced_button_command_latch.sv */
// ---------------------------------------------------------------------------
// debounced_button_command_latch
// Four-channel button debouncer with a one-slot command latch and LED feedback
// ---------------------------------------------------------------------------
// channel  direction  ports
// in       input      in_valid, in_stall, in_func, in_buttons, in_command_shown
// out      output     out_valid, out_stall, out_leds, out_command_valid,
//                     out_command_taken, out_pending_flag
// cfg      input      cfg_we, cfg_index, cfg_wdata
//
// one transaction per cycle while in_stall is low; its result is registered
// in the cycle after acceptance, set by the lane count compare and merge pick
// synchronous reset clears all lane, slot and timer state; no clearing pass
// in_stall rises only while a held result is stalled at the output
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module debounced_button_command_latch (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic [dbcl_pkg::FUNC_WIDTH-1:0]      in_func,
  input  logic [dbcl_pkg::BTN_WIDTH-1:0]       in_buttons,
  input  logic [dbcl_pkg::CMD_WIDTH-1:0]       in_command_shown,
  output logic                                 out_valid,
  input  logic                                 out_stall,
  output logic [dbcl_pkg::LED_WIDTH-1:0]       out_leds,
  output logic                                 out_command_valid,
  output logic [dbcl_pkg::CMD_WIDTH-1:0]       out_command_taken,
  output logic                                 out_pending_flag,
  input  logic                                 cfg_we,
  input  logic [dbcl_pkg::CFG_IDX_WIDTH-1:0]   cfg_index,
  input  logic [dbcl_pkg::CFG_WIDTH-1:0]       cfg_wdata
);
  import dbcl_pkg::*;

  cfg_t      debounce_r, debounce_nxt;
  cfg_t      feedback_r, feedback_nxt;
  logic      out_valid_r, out_valid_nxt;
  result_t   out_r, out_nxt;
  result_t   res;
  chan_vec_t press;
  logic      fire;
  logic      tick_en;

  assign in_stall = out_valid_r & out_stall;
  assign fire     = in_valid & ~in_stall;
  assign tick_en  = fire && (func_t'(in_func) == FUNC_TICK);

  // configuration
  always_comb begin
    debounce_nxt = debounce_r;
    feedback_nxt = feedback_r;
    if (cfg_we) begin
      case (cfg_index)
        CFG_DEBOUNCE: debounce_nxt = cfg_wdata;
        CFG_FEEDBACK: feedback_nxt = cfg_wdata;
        default:      debounce_nxt = debounce_r;
      endcase
    end
  end

  for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_lane
    dbcl_lane u_lane (
      .clk         (clk),
      .rst_n       (rst_n),
      .tick_en     (tick_en),
      .raw         (in_buttons[g]),
      .debounce_ms (debounce_r),
      .press       (press[g])
    );
  end

  dbcl_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .fire          (fire),
    .func          (in_func),
    .command_shown (in_command_shown),
    .press         (press),
    .feedback_ms   (feedback_r),
    .res           (res)
  );

  // output register
  always_comb begin
    out_valid_nxt = out_valid_r;
    out_nxt       = out_r;
    if (fire) begin
      out_valid_nxt = 1'b1;
      out_nxt       = res;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      debounce_r  <= DEBOUNCE_RESET;
      feedback_r  <= FEEDBACK_RESET;
      out_valid_r <= 1'b0;
    end else begin
      debounce_r  <= debounce_nxt;
      feedback_r  <= feedback_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid         = out_valid_r;
  assign out_leds          = out_r.leds;
  assign out_command_valid = out_r.command_valid;
  assign out_command_taken = out_r.command_taken;
  assign out_pending_flag  = out_r.pending_flag;

  `ASSERT_IMPLIES(a_leds_onehot, clk, rst_n, out_valid, $onehot0(out_leds))
  `ASSERT_IMPLIES(a_fetch_clears, clk, rst_n, out_valid && out_command_valid, !out_pending_flag && out_command_taken != '0)
  `ASSERT_NEXT(a_result_follows, clk, rst_n, in_valid && !in_stall, out_valid)

endmodule

/* sim/tb_debounced_button_command_latch.sv */
// ---------------------------------------------------------------------------
// tb_debounced_button_command_latch
// Self-checking bench: a short table of directed transactions, then random
// button sequences held long enough to settle, mixed with fetch, show and
// off requests, over several register settings and idle/stall phases. Every
// result is compared with its typed table row, or else with an in-bench model.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_debounced_button_command_latch;
  import dbcl_pkg::*;

  localparam int   LIMIT_CYCLES = 2000;
  localparam int   PHASE_COUNT  = 8;
  localparam int   PHASE_ITEMS  = 175;
  localparam cmd_t CMD_NONE     = 3'd0;
  localparam cmd_t CMD_ARM      = 3'd1;
  localparam cmd_t CMD_DISARM   = 3'd2;
  localparam cmd_t CMD_FIND     = 3'd3;
  localparam cmd_t CMD_SILENCE  = 3'd4;

  typedef struct {
    func_t     func;
    chan_vec_t buttons;
    cmd_t      cmd;
    bit        typed;
    result_t   res;
  } stim_row_t;

  logic                     clk = 1'b0;
  logic                     rst_n = 1'b0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [FUNC_WIDTH-1:0]    in_func = '0;
  logic [BTN_WIDTH-1:0]     in_buttons = '0;
  logic [CMD_WIDTH-1:0]     in_command_shown = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [LED_WIDTH-1:0]     out_leds;
  logic                     out_command_valid;
  logic [CMD_WIDTH-1:0]     out_command_taken;
  logic                     out_pending_flag;
  logic                     cfg_we = 1'b0;
  logic [CFG_IDX_WIDTH-1:0] cfg_index = '0;
  logic [CFG_WIDTH-1:0]     cfg_wdata = '0;

  // payload tag: typed expectation travels with the transaction
  bit      drv_typed = 1'b0;
  result_t drv_exp = '0;

  int      idle_pct = 0;
  int      stall_pct = 0;
  int      errors = 0;
  int      n_in = 0;
  int      n_out = 0;
  int      n_settings = 0;
  int      quiet_cycles = 0;

  // model state
  logic      raw_seen [CHANNEL_COUNT];
  logic      settled [CHANNEL_COUNT];
  count_t    since_edge [CHANNEL_COUNT];
  cmd_t      slot_cmd;
  logic [3:0] lit_chan;
  cfg_t      lit_left;
  cfg_t      debounce_set;
  cfg_t      feedback_set;

  result_t   awaited_outputs [$];
  stim_row_t dir_rows [$];

  debounced_button_command_latch i_dut (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_func           (in_func),
    .in_buttons        (in_buttons),
    .in_command_shown  (in_command_shown),
    .out_valid         (out_valid),
    .out_stall         (out_stall),
    .out_leds          (out_leds),
    .out_command_valid (out_command_valid),
    .out_command_taken (out_command_taken),
    .out_pending_flag  (out_pending_flag),
    .cfg_we            (cfg_we),
    .cfg_index         (cfg_index),
    .cfg_wdata         (cfg_wdata)
  );

  always #5 clk = ~clk;

  function automatic result_t mk(logic [3:0] l, logic v, cmd_t t, logic p);
    result_t r;
    r.leds          = l;
    r.command_valid = v;
    r.command_taken = t;
    r.pending_flag  = p;
    return r;
  endfunction

  function automatic void light_channel(int ch);
    if (ch < CHANNEL_COUNT) begin
      lit_chan = 4'(ch + 1);
      lit_left = feedback_set;
    end else begin
      lit_chan = '0;
    end
  endfunction

  function automatic result_t debounce_and_latch(func_t f, chan_vec_t b, cmd_t c);
    result_t r;
    r = '0;
    case (f)
      FUNC_TICK: begin
        if (lit_left != 0) lit_left = lit_left - 1'b1;
        if (lit_chan != 0 && lit_left == 0) lit_chan = '0;
        for (int i = 0; i < CHANNEL_COUNT; i++) begin
          if (b[i] != raw_seen[i]) begin
            raw_seen[i]   = b[i];
            since_edge[i] = '0;
          end else if (since_edge[i] != '1) begin
            since_edge[i] = since_edge[i] + 1'b1;
          end
          if (since_edge[i] >= debounce_set && b[i] != settled[i]) begin
            settled[i] = b[i];
            if (b[i] && slot_cmd == CMD_NONE) begin
              slot_cmd = cmd_t'(i + 1);
              light_channel(i);
            end
          end
        end
      end
      FUNC_FETCH: begin
        if (slot_cmd != CMD_NONE) begin
          r.command_valid = 1'b1;
          r.command_taken = slot_cmd;
          slot_cmd        = CMD_NONE;
        end
      end
      FUNC_SHOW: begin
        if (c >= CMD_ARM && c <= CHANNEL_COUNT) light_channel(int'(c) - 1);
        else light_channel(CHANNEL_COUNT);
      end
      default: lit_chan = '0;
    endcase
    if (lit_chan != 0) r.leds = 4'(1) << (lit_chan - 1);
    r.pending_flag = (slot_cmd != CMD_NONE);
    return r;
  endfunction

  // receiver back-pressure
  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < stall_pct);
  end

  // monitor: model update on accepted transactions, compare on results
  always @(posedge clk) begin
    result_t got;
    result_t want;
    if (!rst_n) begin
      for (int i = 0; i < CHANNEL_COUNT; i++) begin
        raw_seen[i]   = 1'b0;
        settled[i]    = 1'b0;
        since_edge[i] = '0;
      end
      slot_cmd     = CMD_NONE;
      lit_chan     = '0;
      lit_left     = '0;
      debounce_set = DEBOUNCE_RESET;
      feedback_set = FEEDBACK_RESET;
    end else begin
      if (cfg_we) begin
        if (cfg_index == CFG_DEBOUNCE) debounce_set = cfg_wdata;
        else if (cfg_index == CFG_FEEDBACK) feedback_set = cfg_wdata;
      end
      if (out_valid && !out_stall) begin
        got = mk(out_leds, out_command_valid, out_command_taken, out_pending_flag);
        n_out++;
        if (awaited_outputs.size() == 0) begin
          errors++;
          $display("%0t unexpected result: leds=%h valid=%b taken=%0d pending=%b",
                   $time, got.leds, got.command_valid, got.command_taken,
                   got.pending_flag);
        end else begin
          want = awaited_outputs.pop_front();
          if (got.leds != want.leds || got.command_valid != want.command_valid ||
              got.command_taken != want.command_taken ||
              got.pending_flag != want.pending_flag) begin
            errors++;
            $display("%0t mismatch: expected leds=%h valid=%b taken=%0d pending=%b",
                     $time, want.leds, want.command_valid, want.command_taken,
                     want.pending_flag);
            $display("%0t           actual   leds=%h valid=%b taken=%0d pending=%b",
                     $time, got.leds, got.command_valid, got.command_taken,
                     got.pending_flag);
          end
        end
      end
      if (in_valid && !in_stall) begin
        want = debounce_and_latch(func_t'(in_func), in_buttons, in_command_shown);
        n_in++;
        awaited_outputs.push_back(drv_typed ? drv_exp : want);
      end
    end
  end

  // watchdog on cycles without any transaction
  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= LIMIT_CYCLES) begin
      $display("%0t watchdog: no transaction for %0d cycles", $time, LIMIT_CYCLES);
      $display("RESULT: ERROR");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  task automatic send_item(func_t f, chan_vec_t b, cmd_t c, bit typed, result_t exp);
    while ($urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid         <= 1'b1;
    in_func          <= f;
    in_buttons       <= b;
    in_command_shown <= c;
    drv_typed        <= typed;
    drv_exp          <= exp;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_outputs.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic set_config(cfg_t deb, cfg_t fb);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_DEBOUNCE;
    cfg_wdata <= deb;
    @(posedge clk);
    cfg_index <= CFG_FEEDBACK;
    cfg_wdata <= fb;
    @(posedge clk);
    cfg_we    <= 1'b0;
    n_settings++;
  endtask

  task automatic add_row(func_t f, chan_vec_t b, cmd_t c, bit typed, result_t r);
    stim_row_t row;
    row.func    = f;
    row.buttons = b;
    row.cmd     = c;
    row.typed   = typed;
    row.res     = r;
    dir_rows.push_back(row);
  endtask

  task automatic run_rows();
    foreach (dir_rows[k]) begin
      send_item(dir_rows[k].func, dir_rows[k].buttons, dir_rows[k].cmd,
                dir_rows[k].typed, dir_rows[k].res);
    end
    dir_rows.delete();
    drain();
  endtask

  initial begin
    chan_vec_t held;
    chan_vec_t b;
    cfg_t      deb;
    cfg_t      fb;
    int        r;
    rst_n <= 1'b0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;
    n_settings = 1;

    // reset settings: show, fetch, off and unsettled presses
    add_row(FUNC_TICK,  4'h0, CMD_NONE,    1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_FETCH, 4'hf, CMD_SILENCE, 1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_SHOW,  4'h0, CMD_NONE,    1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_SHOW,  4'h0, CMD_ARM,     1'b1, mk(4'h1, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_SHOW,  4'h0, CMD_ARM,     1'b1, mk(4'h1, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_OFF,   4'hf, 3'd7,        1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_SHOW,  4'h0, CMD_SILENCE, 1'b1, mk(4'h8, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_SHOW,  4'h0, 3'd5,        1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_SHOW,  4'hf, 3'd7,        1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_TICK,  4'hf, CMD_NONE,    1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_TICK,  4'h0, CMD_NONE,    1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    run_rows();

    // zero debounce and zero feedback time
    set_config(16'd0, 16'd0);
    add_row(FUNC_TICK,  4'h1, CMD_NONE, 1'b1, mk(4'h1, 1'b0, CMD_NONE, 1'b1));
    add_row(FUNC_TICK,  4'h1, CMD_NONE, 1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b1));
    add_row(FUNC_TICK,  4'he, CMD_NONE, 1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b1));
    add_row(FUNC_FETCH, 4'h0, CMD_NONE, 1'b1, mk(4'h0, 1'b1, CMD_ARM,  1'b0));
    add_row(FUNC_FETCH, 4'h0, CMD_NONE, 1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_TICK,  4'h0, CMD_NONE, 1'b1, mk(4'h0, 1'b0, CMD_NONE, 1'b0));
    add_row(FUNC_TICK,  4'ha, CMD_NONE, 1'b1, mk(4'h2, 1'b0, CMD_NONE, 1'b1));
    add_row(FUNC_FETCH, 4'h5, CMD_FIND, 1'b0, '0);
    add_row(FUNC_OFF,   4'h0, CMD_NONE, 1'b0, '0);
    run_rows();

    // top of range for both registers
    set_config(16'hffff, 16'hffff);
    add_row(FUNC_TICK, 4'hf, CMD_NONE,   1'b0, '0);
    add_row(FUNC_SHOW, 4'h0, CMD_FIND,   1'b0, '0);
    add_row(FUNC_TICK, 4'hf, CMD_NONE,   1'b0, '0);
    add_row(FUNC_SHOW, 4'h0, CMD_DISARM, 1'b0, '0);
    add_row(FUNC_TICK, 4'h0, CMD_NONE,   1'b0, '0);
    run_rows();

    held = '0;
    for (int p = 0; p < PHASE_COUNT; p++) begin
      case (p % 4)
        0: begin idle_pct = 0;  stall_pct = 0;  end
        1: begin idle_pct = 70; stall_pct = 0;  end
        2: begin idle_pct = 0;  stall_pct = 70; end
        default: begin idle_pct = 38; stall_pct = 38; end
      endcase
      deb = (p == 0) ? 16'd0 : (p == 3) ? cfg_t'($urandom_range(10, 30)) :
            (p == 6) ? 16'd1 : cfg_t'($urandom_range(1, 8));
      fb  = (p == 1) ? 16'd0 : (p == 2) ? 16'hffff : (p == 5) ? 16'd1 :
            cfg_t'($urandom_range(1, 20));
      set_config(deb, fb);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        r = $urandom_range(0, 99);
        if (r < 68) begin
          if ($urandom_range(0, 9) == 0) held = held ^ chan_vec_t'(1 << $urandom_range(0, 3));
          if ($urandom_range(0, 29) == 0) held = chan_vec_t'($urandom);
          b = held;
          // short contact bounce
          if ($urandom_range(0, 15) == 0) b = b ^ chan_vec_t'(1 << $urandom_range(0, 3));
          send_item(FUNC_TICK, b, cmd_t'($urandom), 1'b0, '0);
        end else if (r < 82) begin
          send_item(FUNC_FETCH, chan_vec_t'($urandom), cmd_t'($urandom), 1'b0, '0);
        end else if (r < 94) begin
          send_item(FUNC_SHOW, chan_vec_t'($urandom), cmd_t'($urandom_range(0, 7)), 1'b0,
                    '0);
        end else begin
          send_item(FUNC_OFF, chan_vec_t'($urandom), cmd_t'($urandom), 1'b0, '0);
        end
      end
      drain();
    end

    if (awaited_outputs.size() != 0) begin
      errors++;
      $display("%0t %0d results never arrived", $time, awaited_outputs.size());
    end
    $display("covered %0d transactions in and %0d results out over %0d register settings,",
             n_in, n_out, n_settings);
    $display("with directed edge cases and random settle, bounce, fetch and show traffic");
    if (errors == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
